// ----- src/cordic_sin_cos_top_defines.svh -----
// Assertion macros shared by the CORDIC sine and cosine design files.
`ifndef CORDIC_SIN_COS_TOP_DEFINES_SVH
`define CORDIC_SIN_COS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define CSC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSC_ASSERT_CLK(lbl, prop, msg)
`define CSC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- src/csc_pkg.sv -----
// Constants, arctangent table and helper function for the CORDIC sine and cosine block.
package csc_pkg;

  localparam int ANGLE_W    = 18;
  localparam int RESULT_W   = 18;
  localparam int TABLE_SIZE = 24;
  localparam int TABLE_FRAC = 30;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Gain 0.6073 held as an exact ratio.
  localparam int GAIN_NUM  = 6073;
  localparam int GAIN_DEN  = 10000;
  localparam int GAIN_HALF = 5000;

  // atan(2^-i) scaled by 2^30 and rounded to nearest.
  localparam logic [29:0] ATAN_Q30 [TABLE_SIZE] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // Arctangent of step idx brought to fb fraction bits, rounded to nearest.
  function automatic logic [30:0] atan_fixed(input int idx, input int fb);
    logic [30:0] t;
    int          sh;
    t  = {1'b0, ATAN_Q30[idx]};
    sh = TABLE_FRAC - fb;
    if (sh == 0) begin
      return t;
    end
    return (t + (31'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ----- src/csc_if.sv -----
// Stream interfaces for the angle input channel and the sine and cosine result channel.
interface csc_angle_if;
  import csc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface csc_result_if;
  import csc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] sine;
  logic signed [RESULT_W-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// ----- src/csc_rot_stage.sv -----
// One registered CORDIC rotation step with its own valid bit and ready.
module csc_rot_stage #(
  parameter int STAGE         = 0,
  parameter int FRACTION_BITS = 16,
  parameter int XW            = FRACTION_BITS + 3,
  parameter int ZW            = ((FRACTION_BITS + 3 > 18) ? FRACTION_BITS + 3 : 18) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  import csc_pkg::*;

  localparam logic [30:0] A_FULL = atan_fixed(STAGE, FRACTION_BITS);
  localparam logic signed [ZW-1:0] A_STEP = signed'(ZW'(A_FULL));

  logic                 valid_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 load;
  logic signed [XW-1:0] dx, dy;

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  // Arithmetic shifts round towards minus infinity.
  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  always_comb begin
    if (z_i[ZW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + A_STEP;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - A_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_valid = valid_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;

endmodule

// ----- src/csc_gain.sv -----
// Four-stage gain unit: scales both lanes by 6073/10000 with rounding and saturates.
`include "cordic_sin_cos_top_defines.svh"

module csc_gain #(
  parameter int FRACTION_BITS = 16,
  parameter int XW            = FRACTION_BITS + 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [XW-1:0]                x_i,
  input  logic signed [XW-1:0]                y_i,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [csc_pkg::RESULT_W-1:0] sine,
  output logic signed [csc_pkg::RESULT_W-1:0] cosine
);
  import csc_pkg::*;

  localparam int NST = 4;
  localparam int PW  = XW + 13;
  localparam int KW  = XW + 14;
  localparam int MW  = XW + 32;
  localparam int RW  = XW + 1;
  localparam int SW  = (RW > RESULT_W + 1) ? RW : RESULT_W + 1;
  localparam logic [63:0] RECIP = (64'd6073 << 32) / 64'd10000;
  localparam logic [63:0] HALF_ULP = 64'h8000_0000;

  logic [NST-1:0] valid_r;
  logic [NST-1:0] load;
  logic [NST-1:0] next_ready;

  // Lane 0 carries y (sine), lane 1 carries x (cosine).
  logic signed [XW-1:0]       lane_in [2];
  logic                       neg_a_r [2], neg_b_r [2], neg_c_r [2];
  logic [XW-1:0]              m_r [2], m_nxt [2];
  logic [XW-1:0]              q0_b_r [2], q0_nxt [2], q0_c_r [2];
  logic [PW-1:0]              p_b_r [2], p_nxt [2], p_c_r [2];
  logic [KW-1:0]              qk_r [2], qk_nxt [2];
  logic [MW-1:0]              prod [2];
  logic [KW-1:0]              resid [2];
  logic [XW-1:0]              q_fin [2];
  logic signed [RW-1:0]       mag [2], res [2];
  logic signed [SW-1:0]       ext [2];
  logic signed [RESULT_W-1:0] sat_nxt [2], sat_r [2];

  assign lane_in[0] = y_i;
  assign lane_in[1] = x_i;

  // Per-stage ready chain, so bubbles are squeezed out during a stall.
  // It is worked out from the output end so that each stage sees its successor's load.
  always_comb begin
    next_ready[NST-1] = out_ready;
    load[NST-1]       = !valid_r[NST-1] || next_ready[NST-1];
    for (int k = NST - 2; k >= 0; k--) begin
      next_ready[k] = load[k+1];
      load[k]       = !valid_r[k] || next_ready[k];
    end
  end

  assign in_ready = load[0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      m_nxt[l]  = lane_in[l][XW-1] ? (~lane_in[l] + 1'b1) : lane_in[l];
      prod[l]   = MW'(m_r[l]) * MW'(RECIP) + MW'(HALF_ULP);
      q0_nxt[l] = prod[l][MW-1:32];
      p_nxt[l]  = PW'(m_r[l]) * PW'(GAIN_NUM) + PW'(GAIN_HALF);
      qk_nxt[l] = KW'(q0_b_r[l]) * KW'(GAIN_DEN);
      // The reciprocal estimate is low by at most one, so one correction suffices.
      resid[l]  = KW'(p_c_r[l]) - qk_r[l];
      q_fin[l]  = q0_c_r[l] + XW'(resid[l] >= KW'(GAIN_DEN));
      mag[l]    = signed'({1'b0, q_fin[l]});
      res[l]    = neg_c_r[l] ? -mag[l] : mag[l];
      ext[l]    = SW'(res[l]);
      if (ext[l] > SW'(OUT_MAX)) begin
        sat_nxt[l] = RESULT_W'(OUT_MAX);
      end else if (ext[l] < SW'(OUT_MIN)) begin
        sat_nxt[l] = RESULT_W'(OUT_MIN);
      end else begin
        sat_nxt[l] = RESULT_W'(ext[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (load[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (load[0] && in_valid) begin
        neg_a_r[l] <= lane_in[l][XW-1];
        m_r[l]     <= m_nxt[l];
      end
      if (load[1] && valid_r[0]) begin
        neg_b_r[l] <= neg_a_r[l];
        q0_b_r[l]  <= q0_nxt[l];
        p_b_r[l]   <= p_nxt[l];
      end
      if (load[2] && valid_r[1]) begin
        neg_c_r[l] <= neg_b_r[l];
        q0_c_r[l]  <= q0_b_r[l];
        p_c_r[l]   <= p_b_r[l];
        qk_r[l]    <= qk_nxt[l];
      end
      if (load[3] && valid_r[2]) begin
        sat_r[l] <= sat_nxt[l];
      end
    end
  end

  assign out_valid = valid_r[NST-1];
  assign sine      = sat_r[0];
  assign cosine    = sat_r[1];

  `CSC_ASSERT_CLK(a_estimate_not_high, valid_r[2] |-> (KW'(p_c_r[0]) >= qk_r[0]) && (KW'(p_c_r[1]) >= qk_r[1]), "gain quotient estimate above the true quotient")
  `CSC_ASSERT_CLK(a_estimate_close, valid_r[2] |-> (resid[0] < KW'(2 * GAIN_DEN)) && (resid[1] < KW'(2 * GAIN_DEN)), "gain quotient estimate needs more than one correction")

endmodule

// ----- src/cordic_sin_cos_top.sv -----
// Top level of the pipelined CORDIC sine and cosine block.
//
//  channel  | direction | payload                    | transfer when
//  in_ch    | in        | angle (18 bit signed, Q16) | in_ch.valid && in_ch.ready
//  out_ch   | out       | sine, cosine (18 bit, Q16) | out_ch.valid && out_ch.ready
//
// One angle enters per cycle while the output is not stalled; each result passes through N
// rotation registers, one per step, where N is ITERATIONS capped at the 24-entry table, then
// through four gain stages.
// Reset clears only the valid bit of every stage; data registers keep their contents.
// Every stage has its own ready, so a stalled output fills empty stages before the input
// is held, and nothing is dropped or repeated.
`include "cordic_sin_cos_top_defines.svh"

module cordic_sin_cos_top #(
  parameter int ITERATIONS    = 10,
  parameter int FRACTION_BITS = 16
) (
  input logic          clk,
  input logic          rst_n,
  csc_angle_if.sink    in_ch,
  csc_result_if.source out_ch
);
  import csc_pkg::*;

  localparam int N  = (ITERATIONS < TABLE_SIZE) ? ITERATIONS : TABLE_SIZE;
  localparam int XW = FRACTION_BITS + 3;
  localparam int ZW = ((FRACTION_BITS + 3 > ANGLE_W) ? FRACTION_BITS + 3 : ANGLE_W) + 1;

  logic                 v_s   [N+1];
  logic                 rdy_s [N+1];
  logic signed [XW-1:0] x_s   [N+1];
  logic signed [XW-1:0] y_s   [N+1];
  logic signed [ZW-1:0] z_s   [N+1];

  // The vector starts at (1, 0) with the angle as residual.
  assign v_s[0]      = in_ch.valid;
  assign in_ch.ready = rdy_s[0];
  assign x_s[0]      = XW'(1) << FRACTION_BITS;
  assign y_s[0]      = '0;
  assign z_s[0]      = ZW'(in_ch.angle);

  for (genvar i = 0; i < N; i++) begin : g_rot
    csc_rot_stage #(
      .STAGE         (i),
      .FRACTION_BITS (FRACTION_BITS),
      .XW            (XW),
      .ZW            (ZW)
    ) u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_s[i]),
      .in_ready  (rdy_s[i]),
      .x_i       (x_s[i]),
      .y_i       (y_s[i]),
      .z_i       (z_s[i]),
      .out_valid (v_s[i+1]),
      .out_ready (rdy_s[i+1]),
      .x_o       (x_s[i+1]),
      .y_o       (y_s[i+1]),
      .z_o       (z_s[i+1])
    );
  end

  csc_gain #(
    .FRACTION_BITS (FRACTION_BITS),
    .XW            (XW)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_s[N]),
    .in_ready  (rdy_s[N]),
    .x_i       (x_s[N]),
    .y_i       (y_s[N]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sine      (out_ch.sine),
    .cosine    (out_ch.cosine)
  );

  // The input can only be held back when every stage is full and the output is stalled.
  `CSC_ASSERT_CLK(a_hold_only_when_full, !in_ch.ready |-> out_ch.valid && !out_ch.ready, "input held back while the pipeline has room")
  `CSC_ASSERT_RST(a_no_result_after_reset, !$past(rst_n) |-> !out_ch.valid, "result offered directly after reset")
  `CSC_ASSERT_CLK(a_first_stage_tracks_input, in_ch.valid && in_ch.ready |=> v_s[1], "accepted angle did not reach the first rotation stage")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the pipelined CORDIC sine and cosine block.
`timescale 1ns / 100ps

module tb;
  import csc_pkg::*;

  localparam int ITERATIONS    = 10;
  localparam int FRACTION_BITS = 16;
  localparam int ATAN_STEPS    = 24;
  localparam int ATAN_FRAC     = 30;
  localparam int PIPE_LATENCY  = ITERATIONS + 4;
  localparam int CYCLE_LIMIT   = 200000;

  localparam longint GAIN_MUL   = 6073;
  localparam longint GAIN_DIV   = 10000;
  localparam longint GAIN_ROUND = 5000;
  localparam longint SAT_HIGH   = 131071;
  localparam longint SAT_LOW    = -131072;

  // Angles in Q16 that are worth hitting on purpose.
  localparam int ANGLE_LIMIT = 114032;
  localparam int HALF_PI_Q16 = 102944;
  localparam int ATAN0_Q16   = 51472;
  localparam int ATAN01_Q16  = 21086;

  typedef struct packed {
    logic signed [RESULT_W-1:0] sine;
    logic signed [RESULT_W-1:0] cosine;
    logic signed [ANGLE_W-1:0]  angle;
  } sin_cos_t;

  logic clk;
  logic rst_n;

  csc_angle_if  angle_ch ();
  csc_result_if result_ch ();

  cordic_sin_cos_top #(
    .ITERATIONS   (ITERATIONS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (angle_ch),
    .out_ch(result_ch)
  );

  sin_cos_t pending_sin_cos[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       error_count;
  int       angles_sent;
  int       results_checked;
  int       cycle_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // atan(2^-i) in Q30, rounded to nearest.
  function automatic longint atan_q30(input int idx);
    case (idx)
      0:  return 843314857;
      1:  return 497837829;
      2:  return 263043837;
      3:  return 133525159;
      4:  return 67021687;
      5:  return 33543516;
      6:  return 16775851;
      7:  return 8388437;
      8:  return 4194283;
      9:  return 2097149;
      10: return 1048576;
      11: return 524288;
      12: return 262144;
      13: return 131072;
      14: return 65536;
      15: return 32768;
      16: return 16384;
      17: return 8192;
      18: return 4096;
      19: return 2048;
      20: return 1024;
      21: return 512;
      22: return 256;
      default: return 128;
    endcase
  endfunction

  // Scale by 0.6073, rounding halves away from zero, then clamp to the output width.
  function automatic logic signed [RESULT_W-1:0] gain_and_clamp(input longint v);
    longint mag;
    longint scaled;
    mag    = (v < 0) ? -v : v;
    scaled = (mag * GAIN_MUL + GAIN_ROUND) / GAIN_DIV;
    if (v < 0) begin
      scaled = -scaled;
    end
    if (scaled > SAT_HIGH) begin
      scaled = SAT_HIGH;
    end
    if (scaled < SAT_LOW) begin
      scaled = SAT_LOW;
    end
    return scaled[RESULT_W-1:0];
  endfunction

  function automatic sin_cos_t predict_sin_cos(input logic signed [ANGLE_W-1:0] ang);
    longint   z;
    longint   x;
    longint   y;
    longint   dx;
    longint   dy;
    longint   step_angle;
    int       shift;
    sin_cos_t res;
    z     = ang;
    x     = longint'(1) <<< FRACTION_BITS;
    y     = 0;
    shift = ATAN_FRAC - FRACTION_BITS;
    for (int i = 0; i < ITERATIONS && i < ATAN_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (shift == 0) begin
        step_angle = atan_q30(i);
      end else begin
        step_angle = (atan_q30(i) + (longint'(1) <<< (shift - 1))) >>> shift;
      end
      // A residual of exactly zero turns the positive way.
      if (z < 0) begin
        x = x + dx;
        y = y - dy;
        z = z + step_angle;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - step_angle;
      end
    end
    res.sine   = gain_and_clamp(y);
    res.cosine = gain_and_clamp(x);
    res.angle  = ang;
    return res;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // the transfer.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(negedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= ang;
    @(posedge clk);
    while (!angle_ch.ready) begin
      @(posedge clk);
    end
    pending_sin_cos.push_back(predict_sin_cos(ang));
    angles_sent++;
    @(negedge clk);
  endtask

  task automatic test_directed_angles();
    int angle_list[$];
    angle_list = '{0, 1, -1, ANGLE_LIMIT, -ANGLE_LIMIT, ANGLE_LIMIT + 1, -ANGLE_LIMIT - 1,
                   HALF_PI_Q16, -HALF_PI_Q16, ATAN0_Q16, -ATAN0_Q16, ATAN01_Q16,
                   -ATAN01_Q16, 65536, -65536, 32768, -32768, 131071, -131072,
                   131070, -131071, 87381, -87381};
    foreach (angle_list[k]) begin
      send_angle(ANGLE_W'(angle_list[k]));
    end
  endtask

  // Mostly angles in the usable range, with some anywhere in the 18-bit field.
  task automatic test_random_angles(input int count);
    int raw;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 85) begin
        raw = int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
      end else begin
        raw = int'($urandom_range(262143));
      end
      send_angle(raw[ANGLE_W-1:0]);
    end
  endtask

  // The sender holds off until the pipeline has emptied, then resumes.
  task automatic test_drain_pause();
    test_random_angles(16);
    angle_ch.valid <= 1'b0;
    while (pending_sin_cos.size() != 0) begin
      @(negedge clk);
    end
    test_random_angles(16);
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sin_cos_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_sin_cos.size() == 0) begin
        $error("unexpected result transfer: sine %0d cosine %0d",
               result_ch.sine, result_ch.cosine);
        error_count++;
      end else begin
        want = pending_sin_cos.pop_front();
        if (result_ch.sine !== want.sine) begin
          $error("sine for angle %0d: expected %0d actual %0d",
                 want.angle, want.sine, result_ch.sine);
          error_count++;
        end
        if (result_ch.cosine !== want.cosine) begin
          $error("cosine for angle %0d: expected %0d actual %0d",
                 want.angle, want.cosine, result_ch.cosine);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[cordic_sin_cos_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    angle_ch.valid  = 1'b0;
    angle_ch.angle  = '0;
    result_ch.ready = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    error_count     = 0;
    angles_sent     = 0;
    results_checked = 0;
    cycle_count     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 72;
    test_directed_angles();
    test_random_angles(480);
    test_drain_pause();

    send_idle_pct = 72;
    recv_idle_pct = 11;
    test_random_angles(510);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_angles(510);

    angle_ch.valid <= 1'b0;
    while (pending_sin_cos.size() != 0) begin
      @(negedge clk);
    end
    repeat (2 * PIPE_LATENCY) @(negedge clk);

    $display("Sent %0d angles (directed edges, usable range and full field) under three",
             angles_sent);
    $display("stall patterns and one drain pause; %0d sine/cosine pairs compared.",
             results_checked);
    if (error_count == 0) begin
      $display("[cordic_sin_cos_top] OK");
    end else begin
      $display("[cordic_sin_cos_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/csc_pkg.sv
src/csc_if.sv
src/csc_rot_stage.sv
src/csc_gain.sv
src/cordic_sin_cos_top.sv
tb/tb.sv
